FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent assertions used in checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/lcf_pkg.sv
// ---------------------------------------------------------------------------
// lcf_pkg
// Types and constants shared by the LED command framer modules.
// ---------------------------------------------------------------------------
package lcf_pkg;

   // item kinds
   localparam logic KIND_REQ = 1'b0;
   localparam logic KIND_ACK = 1'b1;

   // request opcodes
   localparam logic [2:0] OP_COLOR  = 3'd0;
   localparam logic [2:0] OP_BRIGHT = 3'd1;
   localparam logic [2:0] OP_ONOFF  = 3'd2;
   localparam logic [2:0] OP_BLINK  = 3'd3;
   localparam logic [2:0] OP_BREATH = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SKIP    = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_AWAIT   = 3'd3;
   localparam logic [2:0] ST_WFAIL   = 3'd4;
   localparam logic [2:0] ST_RFAIL   = 3'd5;
   localparam logic [2:0] ST_REJECT  = 3'd6;

   // cached LED modes
   localparam logic [2:0] MODE_UNKNOWN = 3'd0;
   localparam logic [2:0] MODE_OFF     = 3'd1;
   localparam logic [2:0] MODE_ON      = 3'd2;
   localparam logic [2:0] MODE_BLINK   = 3'd3;
   localparam logic [2:0] MODE_BREATH  = 3'd4;

   // device command bytes
   localparam logic [7:0] CMD_BRIGHT = 8'h01;
   localparam logic [7:0] CMD_COLOR  = 8'h02;
   localparam logic [7:0] CMD_ONOFF  = 8'h03;
   localparam logic [7:0] CMD_BLINK  = 8'h04;
   localparam logic [7:0] CMD_BREATH = 8'h05;

   // bus error codes and acknowledge byte
   localparam logic [1:0] BERR_NONE  = 2'd0;
   localparam logic [1:0] BERR_WRITE = 2'd1;
   localparam logic [7:0] ACK_ACCEPT = 8'h01;

   // frame layout
   localparam int         FRAME_LEN   = 12;
   localparam int         CNT_W       = 4;
   localparam logic [7:0] FRAME_HDR_A = 8'ha0;
   localparam logic [7:0] FRAME_HDR_B = 8'h01;
   localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(FRAME_LEN - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EVAL  = 3'b010,
      S_FRAME = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic             load_in;
      logic             start_pend;
      logic             retry;
      logic             commit;
      logic             purge;
      logic             emit_status;
      logic [2:0]       status;
      logic             att_zero;
      logic             emit_byte;
      logic [CNT_W-1:0] byte_sel;
      logic             byte_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       item_ack;
      logic       pend_busy;
      logic       req_bad;
      logic       req_skip;
      logic       ack_good;
      logic       attempts_left;
      logic [2:0] fail_cause;
   } stat_type;

   function automatic logic [7:0] cmd_of_op(input logic [2:0] op);
      logic [7:0] c;
      case (op)
         OP_COLOR:  c = CMD_COLOR;
         OP_BRIGHT: c = CMD_BRIGHT;
         OP_ONOFF:  c = CMD_ONOFF;
         OP_BLINK:  c = CMD_BLINK;
         OP_BREATH: c = CMD_BREATH;
         default:   c = CMD_COLOR;
      endcase
      return c;
   endfunction

endpackage

FILE: hw/rtl/lcf_datapath.sv
// ---------------------------------------------------------------------------
// lcf_datapath
// Input capture, shadow cache, pending command, frame builder, result regs.
// ---------------------------------------------------------------------------
module lcf_datapath #(
   parameter int LED_COUNT    = 16,
   parameter int MAX_ATTEMPTS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_item_kind,
   input  logic [2:0]        req_opcode,
   input  logic [7:0]        req_led_index,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic [7:0]        req_level,
   input  logic              req_turn_on,
   input  logic [15:0]       req_on_time_ms,
   input  logic [15:0]       req_off_time_ms,
   input  logic [1:0]        req_bus_error,
   input  logic [7:0]        req_ack_value,
   input  lcf_pkg::cmd_type  cmd,
   output lcf_pkg::stat_type stat,
   output logic              rsp_valid,
   output logic [7:0]        rsp_frame_byte,
   output logic              rsp_is_frame,
   output logic              rsp_last,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_attempt_number
);

   localparam int         IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);
   localparam logic [3:0] ATT_LIMIT = 4'(MAX_ATTEMPTS);

   // captured beat
   logic        kind_ff;
   logic [2:0]  op_ff;
   logic [7:0]  led_ff, red_ff, green_ff, blue_ff, level_ff, ack_ff;
   logic        turn_on_ff;
   logic [15:0] on_time_ff, off_time_ff;
   logic [1:0]  berr_ff;

   // shadow cache
   logic [23:0] color_mem  [LED_COUNT];
   logic [7:0]  bright_mem [LED_COUNT];
   logic [2:0]  mode_mem   [LED_COUNT];
   logic [31:0] time_mem   [LED_COUNT];
   logic [LED_COUNT-1:0] color_vld_ff, bright_vld_ff, mode_vld_ff, time_vld_ff;

   logic [23:0] color_rd_ff;
   logic [7:0]  bright_rd_ff;
   logic [2:0]  mode_rd_ff;
   logic [31:0] time_rd_ff;
   logic        color_rv_ff, bright_rv_ff, mode_rv_ff, time_rv_ff;

   // pending command
   logic        pend_busy_ff;
   logic [7:0]  pend_led_ff;
   logic [2:0]  pend_op_ff;
   logic [31:0] pend_params_ff;
   logic [3:0]  attempt_ff;

   logic [IDX_W-1:0] rd_idx, wr_idx;
   logic [16:0] cycle_c;
   logic        timed_c, skip_c;
   logic [31:0] params_c;
   logic [23:0] color_q;
   logic [7:0]  bright_q;
   logic [2:0]  mode_q, want_mode_c, commit_mode_c;
   logic [31:0] time_q, commit_time_c;
   logic        wr_color, wr_bright, wr_mode, wr_time;
   logic [7:0]  cmd_byte_c;
   logic [15:0] sum_c;
   logic [7:0]  frame_c [lcf_pkg::FRAME_LEN];

   assign rd_idx = req_led_index[IDX_W-1:0];
   assign wr_idx = pend_led_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         kind_ff     <= req_item_kind;
         op_ff       <= req_opcode;
         led_ff      <= req_led_index;
         red_ff      <= req_red;
         green_ff    <= req_green;
         blue_ff     <= req_blue;
         level_ff    <= req_level;
         turn_on_ff  <= req_turn_on;
         on_time_ff  <= req_on_time_ms;
         off_time_ff <= req_off_time_ms;
         berr_ff     <= req_bus_error;
         ack_ff      <= req_ack_value;
      end
   end

   // cache read, registered, issued with the input beat
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         color_rd_ff  <= color_mem[rd_idx];
         bright_rd_ff <= bright_mem[rd_idx];
         mode_rd_ff   <= mode_mem[rd_idx];
         time_rd_ff   <= time_mem[rd_idx];
         color_rv_ff  <= color_vld_ff[rd_idx];
         bright_rv_ff <= bright_vld_ff[rd_idx];
         mode_rv_ff   <= mode_vld_ff[rd_idx];
         time_rv_ff   <= time_vld_ff[rd_idx];
      end
   end

   // cache write on a good acknowledge
   always_comb begin
      wr_color      = 1'b0;
      wr_bright     = 1'b0;
      wr_mode       = 1'b0;
      wr_time       = 1'b0;
      commit_mode_c = (pend_op_ff == lcf_pkg::OP_BREATH) ? lcf_pkg::MODE_BREATH
                                                         : lcf_pkg::MODE_BLINK;
      case (pend_op_ff)
         lcf_pkg::OP_COLOR:  wr_color  = cmd.commit;
         lcf_pkg::OP_BRIGHT: wr_bright = cmd.commit;
         lcf_pkg::OP_ONOFF: begin
            wr_mode       = cmd.commit;
            commit_mode_c = (pend_params_ff[31:24] != 8'd0) ? lcf_pkg::MODE_ON
                                                            : lcf_pkg::MODE_OFF;
         end
         default: begin
            wr_mode = cmd.commit;
            wr_time = cmd.commit;
         end
      endcase
      // params hold cycle and on time; off time is their difference
      commit_time_c = {pend_params_ff[15:0], pend_params_ff[31:16] - pend_params_ff[15:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_color)  color_mem[wr_idx]  <= pend_params_ff[31:8];
      if (wr_bright) bright_mem[wr_idx] <= pend_params_ff[31:24];
      if (wr_mode)   mode_mem[wr_idx]   <= commit_mode_c;
      if (wr_time)   time_mem[wr_idx]   <= commit_time_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_vld_ff  <= '0;
         bright_vld_ff <= '0;
         mode_vld_ff   <= '0;
         time_vld_ff   <= '0;
      end else if (cmd.purge) begin
         color_vld_ff[wr_idx]  <= 1'b0;
         bright_vld_ff[wr_idx] <= 1'b0;
         mode_vld_ff[wr_idx]   <= 1'b0;
         time_vld_ff[wr_idx]   <= 1'b0;
      end else begin
         if (wr_color)  color_vld_ff[wr_idx]  <= 1'b1;
         if (wr_bright) bright_vld_ff[wr_idx] <= 1'b1;
         if (wr_mode)   mode_vld_ff[wr_idx]   <= 1'b1;
         if (wr_time)   time_vld_ff[wr_idx]   <= 1'b1;
      end
   end

   // invalid entries read as zero
   assign color_q  = color_rv_ff  ? color_rd_ff  : '0;
   assign bright_q = bright_rv_ff ? bright_rd_ff : '0;
   assign mode_q   = mode_rv_ff   ? mode_rd_ff   : lcf_pkg::MODE_UNKNOWN;
   assign time_q   = time_rv_ff   ? time_rd_ff   : '0;

   // request classification
   always_comb begin
      cycle_c     = {1'b0, on_time_ff} + {1'b0, off_time_ff};
      timed_c     = (op_ff == lcf_pkg::OP_BLINK) || (op_ff == lcf_pkg::OP_BREATH);
      want_mode_c = (op_ff == lcf_pkg::OP_BREATH) ? lcf_pkg::MODE_BREATH
                                                  : lcf_pkg::MODE_BLINK;
      case (op_ff)
         lcf_pkg::OP_COLOR: begin
            skip_c   = color_rv_ff && (color_q == {red_ff, green_ff, blue_ff});
            params_c = {red_ff, green_ff, blue_ff, 8'd0};
         end
         lcf_pkg::OP_BRIGHT: begin
            skip_c   = bright_rv_ff && (bright_q == level_ff);
            params_c = {level_ff, 24'd0};
         end
         lcf_pkg::OP_ONOFF: begin
            skip_c   = mode_q == (turn_on_ff ? lcf_pkg::MODE_ON : lcf_pkg::MODE_OFF);
            params_c = {7'd0, turn_on_ff, 24'd0};
         end
         default: begin
            skip_c   = (mode_q == want_mode_c) && (time_q == {on_time_ff, off_time_ff});
            params_c = {cycle_c[15:0], on_time_ff};
         end
      endcase
   end

   always_comb begin
      stat.item_ack      = kind_ff == lcf_pkg::KIND_ACK;
      stat.pend_busy     = pend_busy_ff;
      stat.req_bad       = ({1'b0, led_ff} >= LED_LIMIT) || (op_ff > lcf_pkg::OP_BREATH)
                           || (timed_c && cycle_c[16]);
      stat.req_skip      = skip_c;
      stat.ack_good      = (berr_ff == lcf_pkg::BERR_NONE) && (ack_ff == lcf_pkg::ACK_ACCEPT);
      stat.attempts_left = attempt_ff < ATT_LIMIT;
      if (berr_ff == lcf_pkg::BERR_WRITE)
         stat.fail_cause = lcf_pkg::ST_WFAIL;
      else if (berr_ff != lcf_pkg::BERR_NONE)
         stat.fail_cause = lcf_pkg::ST_RFAIL;
      else
         stat.fail_cause = lcf_pkg::ST_REJECT;
   end

   // pending command
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_busy_ff <= 1'b0;
         attempt_ff   <= '0;
      end else if (cmd.start_pend) begin
         pend_busy_ff <= 1'b1;
         attempt_ff   <= 4'd1;
      end else if (cmd.retry) begin
         attempt_ff   <= attempt_ff + 4'd1;
      end else if (cmd.commit || cmd.purge) begin
         pend_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pend) begin
         pend_led_ff    <= led_ff;
         pend_op_ff     <= op_ff;
         pend_params_ff <= params_c;
      end
   end

   // frame image
   always_comb begin
      cmd_byte_c = lcf_pkg::cmd_of_op(pend_op_ff);
      sum_c = 16'(lcf_pkg::FRAME_HDR_A) + 16'(lcf_pkg::FRAME_HDR_B) + 16'(cmd_byte_c)
            + 16'(pend_params_ff[31:24]) + 16'(pend_params_ff[23:16])
            + 16'(pend_params_ff[15:8]) + 16'(pend_params_ff[7:0]);
      frame_c[0]  = pend_led_ff;
      frame_c[1]  = lcf_pkg::FRAME_HDR_A;
      frame_c[2]  = lcf_pkg::FRAME_HDR_B;
      frame_c[3]  = 8'd0;
      frame_c[4]  = 8'd0;
      frame_c[5]  = cmd_byte_c;
      frame_c[6]  = pend_params_ff[31:24];
      frame_c[7]  = pend_params_ff[23:16];
      frame_c[8]  = pend_params_ff[15:8];
      frame_c[9]  = pend_params_ff[7:0];
      frame_c[10] = sum_c[15:8];
      frame_c[11] = sum_c[7:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid <= 1'b0;
      else
         rsp_valid <= cmd.emit_byte || cmd.emit_status;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_byte) begin
         rsp_frame_byte     <= frame_c[cmd.byte_sel];
         rsp_is_frame       <= 1'b1;
         rsp_last           <= cmd.byte_last;
         rsp_status         <= lcf_pkg::ST_AWAIT;
         rsp_attempt_number <= attempt_ff;
      end else if (cmd.emit_status) begin
         rsp_frame_byte     <= 8'd0;
         rsp_is_frame       <= 1'b0;
         rsp_last           <= 1'b1;
         rsp_status         <= cmd.status;
         rsp_attempt_number <= cmd.att_zero ? 4'd0 : attempt_ff;
      end
   end

endmodule

FILE: hw/rtl/lcf_ctrl.sv
// ---------------------------------------------------------------------------
// lcf_ctrl
// Sequencer: evaluates one beat, then emits a status or a 12-byte frame.
// ---------------------------------------------------------------------------
module lcf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  lcf_pkg::stat_type stat,
   output lcf_pkg::cmd_type  cmd,
   output logic              busy
);

   lcf_pkg::state_type state_ff, state_in;
   logic [lcf_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcf_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = state_ff != lcf_pkg::S_IDLE;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         lcf_pkg::S_IDLE: begin
            if (start) begin
               cmd.load_in = 1'b1;
               state_in    = lcf_pkg::S_EVAL;
            end
         end
         lcf_pkg::S_EVAL: begin
            state_in = lcf_pkg::S_IDLE;
            if (!stat.item_ack) begin
               if (stat.pend_busy) begin
                  // a request while a frame is outstanding is refused
                  cmd.emit_status = 1'b1;
                  cmd.status      = lcf_pkg::ST_INVALID;
               end else if (stat.req_bad) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = lcf_pkg::ST_INVALID;
                  cmd.att_zero    = 1'b1;
               end else if (stat.req_skip) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = lcf_pkg::ST_SKIP;
                  cmd.att_zero    = 1'b1;
               end else begin
                  cmd.start_pend = 1'b1;
                  cnt_in         = '0;
                  state_in       = lcf_pkg::S_FRAME;
               end
            end else begin
               if (!stat.pend_busy) begin
                  cmd.emit_status = 1'b1;
                  cmd.status      = lcf_pkg::ST_INVALID;
                  cmd.att_zero    = 1'b1;
               end else if (stat.ack_good) begin
                  cmd.commit      = 1'b1;
                  cmd.emit_status = 1'b1;
                  cmd.status      = lcf_pkg::ST_OK;
               end else if (stat.attempts_left) begin
                  cmd.retry = 1'b1;
                  cnt_in    = '0;
                  state_in  = lcf_pkg::S_FRAME;
               end else begin
                  // out of attempts: drop the LED's cached setting
                  cmd.purge       = 1'b1;
                  cmd.emit_status = 1'b1;
                  cmd.status      = stat.fail_cause;
               end
            end
         end
         lcf_pkg::S_FRAME: begin
            cmd.emit_byte = 1'b1;
            cmd.byte_sel  = cnt_ff;
            cmd.byte_last = cnt_ff == lcf_pkg::LAST_BYTE;
            if (cnt_ff == lcf_pkg::LAST_BYTE)
               state_in = lcf_pkg::S_IDLE;
            else
               cnt_in = cnt_ff + lcf_pkg::CNT_W'(1);
         end
         default: begin
            state_in = lcf_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/led_command_framer_with_cache.sv
// ---------------------------------------------------------------------------
// led_command_framer_with_cache
// LED command framer with per-LED shadow cache and acknowledge retry.
// ---------------------------------------------------------------------------
// Input: one beat is taken on a rising edge with start high and busy low.
// A beat is either an LED request (req_item_kind 0) or the acknowledge
// outcome of the outstanding frame (req_item_kind 1).
// Output: each result is shown for one cycle with rsp_valid high; rsp_last
// marks the final result of a beat. The receiver cannot stall the block.
// Sequencing: a beat that yields one status result keeps busy high through
// the evaluate state; its result shows in the cycle busy falls. A beat that
// sends a frame keeps busy high through evaluate and then the byte-serial
// frame sequencer, one byte per cycle; each byte shows in the cycle after
// it is selected, the last in the cycle busy falls. A new beat may be
// taken in the same cycle the previous last result shows.
// Reset clears the controller, the pending command and all cache valid bits,
// so every cache entry reads as empty; no clearing pass is needed.
// ---------------------------------------------------------------------------
module led_command_framer_with_cache #(
   parameter int LED_COUNT    = 16,
   parameter int MAX_ATTEMPTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_item_kind,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_led_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_level,
   input  logic        req_turn_on,
   input  logic [15:0] req_on_time_ms,
   input  logic [15:0] req_off_time_ms,
   input  logic [1:0]  req_bus_error,
   input  logic [7:0]  req_ack_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_is_frame,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_attempt_number
);

   lcf_pkg::cmd_type  cmd;
   lcf_pkg::stat_type stat;

   lcf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   lcf_datapath #(
      .LED_COUNT    (LED_COUNT),
      .MAX_ATTEMPTS (MAX_ATTEMPTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_item_kind      (req_item_kind),
      .req_opcode         (req_opcode),
      .req_led_index      (req_led_index),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_level          (req_level),
      .req_turn_on        (req_turn_on),
      .req_on_time_ms     (req_on_time_ms),
      .req_off_time_ms    (req_off_time_ms),
      .req_bus_error      (req_bus_error),
      .req_ack_value      (req_ack_value),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_is_frame       (rsp_is_frame),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_attempt_number (rsp_attempt_number)
   );

endmodule

FILE: hw/rtl/lcf_checker.sv
// ---------------------------------------------------------------------------
// lcf_checker
// Port-level checks on the LED command framer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lcf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_is_frame,
   input logic        rsp_last,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_attempt_number
);

   // a taken beat keeps the block busy for at least the evaluate state
   `CHK_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "beat taken but not busy")

   // more frame bytes follow, so the block must still be working
   `CHK_ASSERT(a_mid_frame_busy, clock, reset, (rsp_valid && !rsp_last) |-> busy, "idle mid frame")

   // frame bytes carry the awaiting status and a real attempt number
   `CHK_ASSERT(a_frame_status, clock, reset, (rsp_valid && rsp_is_frame) |-> (rsp_status == lcf_pkg::ST_AWAIT && rsp_attempt_number != 4'd0), "bad frame beat")

   // going idle coincides with the final result of the beat
   `CHK_ASSERT(a_idle_last, clock, reset, $fell(busy) |-> (rsp_valid && rsp_last), "idle without last result")

endmodule

bind led_command_framer_with_cache lcf_checker u_lcf_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_is_frame       (rsp_is_frame),
   .rsp_last           (rsp_last),
   .rsp_status         (rsp_status),
   .rsp_attempt_number (rsp_attempt_number)
);

FILE: tb/sv/lcf_frame_checker.sv
// ----------------------------------------------------------------------------
// lcf_frame_checker
// Watches the request and response channels of the LED command framer, keeps
// its own copy of the shadow cache and pending command, and compares every
// response against the queue of predicted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lcf_frame_checker #(
   parameter int LED_COUNT    = 16,
   parameter int MAX_ATTEMPTS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_item_kind,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_led_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_level,
   input  logic        req_turn_on,
   input  logic [15:0] req_on_time_ms,
   input  logic [15:0] req_off_time_ms,
   input  logic [1:0]  req_bus_error,
   input  logic [7:0]  req_ack_value,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_frame_byte,
   input  logic        rsp_is_frame,
   input  logic        rsp_last,
   input  logic [2:0]  rsp_status,
   input  logic [3:0]  rsp_attempt_number,
   output int          fail_count,
   output int          waiting,
   output int          checked
);

   localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   typedef struct packed {
      logic [7:0] fbyte;
      logic       is_frame;
      logic       last;
      logic [2:0] status;
      logic [3:0] attempt;
   } led_result_type;

   led_result_type framer_results_q[$];

   // shadow cache
   logic [24:0] color_cache [LED_COUNT];
   logic [8:0]  level_cache [LED_COUNT];
   logic [2:0]  mode_cache  [LED_COUNT];
   logic [15:0] on_cache    [LED_COUNT];
   logic [15:0] off_cache   [LED_COUNT];

   // outstanding command
   logic        cmd_open;
   logic [7:0]  cmd_led;
   logic [2:0]  cmd_op;
   logic [31:0] cmd_params;
   logic [3:0]  tries;

   int errors;
   int results_seen;

   assign fail_count = errors;
   assign checked    = results_seen;

   task automatic push_status(input logic [2:0] status, input logic [3:0] attempt);
      framer_results_q.push_back('{8'h00, 1'b0, 1'b1, status, attempt});
   endtask

   task automatic push_frame();
      logic [7:0]  fb [lcf_pkg::FRAME_LEN];
      logic [15:0] sum;
      int          i;
      fb[0] = cmd_led;
      fb[1] = lcf_pkg::FRAME_HDR_A;
      fb[2] = lcf_pkg::FRAME_HDR_B;
      fb[3] = 8'h00;
      fb[4] = 8'h00;
      case (cmd_op)
         lcf_pkg::OP_BRIGHT: fb[5] = lcf_pkg::CMD_BRIGHT;
         lcf_pkg::OP_ONOFF:  fb[5] = lcf_pkg::CMD_ONOFF;
         lcf_pkg::OP_BLINK:  fb[5] = lcf_pkg::CMD_BLINK;
         lcf_pkg::OP_BREATH: fb[5] = lcf_pkg::CMD_BREATH;
         default:            fb[5] = lcf_pkg::CMD_COLOR;
      endcase
      fb[6] = cmd_params[31:24];
      fb[7] = cmd_params[23:16];
      fb[8] = cmd_params[15:8];
      fb[9] = cmd_params[7:0];
      sum = '0;
      for (i = 1; i <= 9; i++) sum += 16'(fb[i]);
      fb[10] = sum[15:8];
      fb[11] = sum[7:0];
      for (i = 0; i < lcf_pkg::FRAME_LEN; i++)
         framer_results_q.push_back('{fb[i], 1'b1, i == lcf_pkg::FRAME_LEN - 1,
                                      lcf_pkg::ST_AWAIT, tries});
   endtask

   task automatic commit_setting();
      logic [15:0]      span;
      logic [IDX_W-1:0] slot;
      span = cmd_params[31:16];
      slot = cmd_led[IDX_W-1:0];
      case (cmd_op)
         lcf_pkg::OP_COLOR:  color_cache[slot] = {1'b1, cmd_params[31:8]};
         lcf_pkg::OP_BRIGHT: level_cache[slot] = {1'b1, cmd_params[31:24]};
         // on/off keeps the cached blink/breath times
         lcf_pkg::OP_ONOFF:  mode_cache[slot] = (cmd_params[31:24] != 8'd0) ? lcf_pkg::MODE_ON
                                                                          : lcf_pkg::MODE_OFF;
         default: begin
            mode_cache[slot] = (cmd_op == lcf_pkg::OP_BREATH) ? lcf_pkg::MODE_BREATH
                                                              : lcf_pkg::MODE_BLINK;
            on_cache[slot]   = cmd_params[15:0];
            off_cache[slot]  = span - cmd_params[15:0];
         end
      endcase
   endtask

   task automatic predict_beat();
      logic [16:0]      span;
      logic [2:0]       want_mode;
      logic [31:0]      params;
      logic [2:0]       cause;
      logic             hit;
      logic [IDX_W-1:0] slot;
      span = {1'b0, req_on_time_ms} + {1'b0, req_off_time_ms};
      slot = req_led_index[IDX_W-1:0];
      if (req_item_kind == lcf_pkg::KIND_REQ) begin
         if (cmd_open) begin
            push_status(lcf_pkg::ST_INVALID, tries);
         end else if (req_led_index >= LED_COUNT || req_opcode > lcf_pkg::OP_BREATH) begin
            push_status(lcf_pkg::ST_INVALID, 4'd0);
         end else if (req_opcode >= lcf_pkg::OP_BLINK && span[16]) begin
            push_status(lcf_pkg::ST_INVALID, 4'd0);
         end else begin
            case (req_opcode)
               lcf_pkg::OP_COLOR: begin
                  hit    = color_cache[slot] == {1'b1, req_red, req_green, req_blue};
                  params = {req_red, req_green, req_blue, 8'h00};
               end
               lcf_pkg::OP_BRIGHT: begin
                  hit    = level_cache[slot] == {1'b1, req_level};
                  params = {req_level, 24'h0};
               end
               lcf_pkg::OP_ONOFF: begin
                  want_mode = req_turn_on ? lcf_pkg::MODE_ON : lcf_pkg::MODE_OFF;
                  hit       = mode_cache[slot] == want_mode;
                  params    = {7'h0, req_turn_on, 24'h0};
               end
               default: begin
                  want_mode = (req_opcode == lcf_pkg::OP_BREATH) ? lcf_pkg::MODE_BREATH
                                                                 : lcf_pkg::MODE_BLINK;
                  hit = mode_cache[slot] == want_mode
                        && on_cache[slot] == req_on_time_ms
                        && off_cache[slot] == req_off_time_ms;
                  params = {span[15:0], req_on_time_ms};
               end
            endcase
            if (hit) begin
               push_status(lcf_pkg::ST_SKIP, 4'd0);
            end else begin
               cmd_open   = 1'b1;
               cmd_led    = req_led_index;
               cmd_op     = req_opcode;
               cmd_params = params;
               tries      = 4'd1;
               push_frame();
            end
         end
      end else if (!cmd_open) begin
         push_status(lcf_pkg::ST_INVALID, 4'd0);
      end else if (req_bus_error == lcf_pkg::BERR_NONE
                   && req_ack_value == lcf_pkg::ACK_ACCEPT) begin
         commit_setting();
         cmd_open = 1'b0;
         push_status(lcf_pkg::ST_OK, tries);
      end else begin
         if (req_bus_error == lcf_pkg::BERR_WRITE)     cause = lcf_pkg::ST_WFAIL;
         else if (req_bus_error != lcf_pkg::BERR_NONE) cause = lcf_pkg::ST_RFAIL;
         else                                          cause = lcf_pkg::ST_REJECT;
         if (tries < MAX_ATTEMPTS) begin
            tries = tries + 4'd1;
            push_frame();
         end else begin
            // out of retries: forget everything known about this LED
            color_cache[cmd_led[IDX_W-1:0]] = '0;
            level_cache[cmd_led[IDX_W-1:0]] = '0;
            mode_cache[cmd_led[IDX_W-1:0]]  = lcf_pkg::MODE_UNKNOWN;
            on_cache[cmd_led[IDX_W-1:0]]    = '0;
            off_cache[cmd_led[IDX_W-1:0]]   = '0;
            cmd_open = 1'b0;
            push_status(cause, tries);
         end
      end
   endtask

   task automatic check_result();
      led_result_type want;
      if (framer_results_q.size() == 0) begin
         $error("unexpected result: status %0d byte %0h", rsp_status, rsp_frame_byte);
         errors++;
      end else begin
         want = framer_results_q.pop_front();
         results_seen++;
         if (rsp_frame_byte !== want.fbyte) begin
            $error("rsp_frame_byte: expected %0h, got %0h", want.fbyte, rsp_frame_byte);
            errors++;
         end
         if (rsp_is_frame !== want.is_frame) begin
            $error("rsp_is_frame: expected %0d, got %0d", want.is_frame, rsp_is_frame);
            errors++;
         end
         if (rsp_last !== want.last) begin
            $error("rsp_last: expected %0d, got %0d", want.last, rsp_last);
            errors++;
         end
         if (rsp_status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
            errors++;
         end
         if (rsp_attempt_number !== want.attempt) begin
            $error("rsp_attempt_number: expected %0d, got %0d",
                   want.attempt, rsp_attempt_number);
            errors++;
         end
      end
   endtask

   initial begin
      errors       = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LED_COUNT; k++) begin
            color_cache[k] = '0;
            level_cache[k] = '0;
            mode_cache[k]  = lcf_pkg::MODE_UNKNOWN;
            on_cache[k]    = '0;
            off_cache[k]   = '0;
         end
         cmd_open   = 1'b0;
         cmd_led    = '0;
         cmd_op     = lcf_pkg::OP_COLOR;
         cmd_params = '0;
         tries      = '0;
         framer_results_q.delete();
         waiting <= 0;
      end else begin
         if (rsp_valid) check_result();
         if (start && !busy) predict_beat();
         waiting <= framer_results_q.size();
      end
   end

endmodule

FILE: tb/sv/led_command_framer_with_cache_test.sv
// ----------------------------------------------------------------------------
// led_command_framer_with_cache_test
// Drives request and acknowledge beats into the LED command framer: a short
// directed pass over the corner cases, then random command/acknowledge
// sequences mixed with malformed beats. Checking lives in lcf_frame_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_command_framer_with_cache_test;

   localparam int LEDS  = 16;
   localparam int TRIES = 5;
   localparam int RANDOM_BEATS = 125;

   localparam logic [1:0] BERR_READ     = 2'd2;
   localparam logic [1:0] BERR_READ_ALT = 2'd3;
   localparam logic [2:0] OP_ILLEGAL    = 3'd7;

   typedef struct {
      logic        kind;
      logic [2:0]  op;
      logic [7:0]  led;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  level;
      logic        turn_on;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
      logic [1:0]  berr;
      logic [7:0]  ack;
   } led_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_item_kind = 1'b0;
   logic [2:0]  req_opcode = '0;
   logic [7:0]  req_led_index = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic [7:0]  req_level = '0;
   logic        req_turn_on = 1'b0;
   logic [15:0] req_on_time_ms = '0;
   logic [15:0] req_off_time_ms = '0;
   logic [1:0]  req_bus_error = '0;
   logic [7:0]  req_ack_value = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_is_frame;
   logic        rsp_last;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_attempt_number;
   int          fail_count;
   int          waiting;
   int          checked;

   int beats = 0;
   bit calm  = 1'b0;

   led_command_framer_with_cache #(.LED_COUNT(LEDS), .MAX_ATTEMPTS(TRIES)) dut (.*);
   lcf_frame_checker #(.LED_COUNT(LEDS), .MAX_ATTEMPTS(TRIES)) checker_i (.*);

   always #5 clock = ~clock;

   function automatic led_beat_type mk(logic kind, logic [2:0] op, logic [7:0] led,
                                       logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                       logic [7:0] level, logic turn_on,
                                       logic [15:0] on_ms, logic [15:0] off_ms,
                                       logic [1:0] berr, logic [7:0] ack);
      led_beat_type b;
      b = '{kind, op, led, red, green, blue, level, turn_on, on_ms, off_ms, berr, ack};
      return b;
   endfunction

   function automatic led_beat_type ack_beat(logic [1:0] berr, logic [7:0] ack);
      return mk(lcf_pkg::KIND_ACK, lcf_pkg::OP_COLOR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                16'd0, 16'd0, berr, ack);
   endfunction

   // random beat, any field value; half of them get an LED index in range
   function automatic led_beat_type noise_beat();
      led_beat_type b;
      b = mk(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
             2'($urandom), 8'($urandom));
      if ($urandom_range(1) != 0) b.led = 8'($urandom_range(LEDS - 1));
      return b;
   endfunction

   function automatic logic [7:0] pooled_byte();
      case ($urandom_range(2))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'h5a;
      endcase
   endfunction

   // mostly well-formed request; half draw from a small value pool to hit the cache
   function automatic led_beat_type request_beat();
      led_beat_type b;
      bit           pool;
      b      = noise_beat();
      pool   = 1'($urandom_range(1));
      b.kind = lcf_pkg::KIND_REQ;
      b.op   = 3'($urandom_range(lcf_pkg::OP_BREATH));
      b.led  = 8'($urandom_range(LEDS - 1));
      if (pool) begin
         b.red    = pooled_byte();
         b.green  = pooled_byte();
         b.blue   = pooled_byte();
         b.level  = pooled_byte();
         b.on_ms  = ($urandom_range(1) != 0) ? 16'd500 : 16'd0;
         b.off_ms = ($urandom_range(1) != 0) ? 16'd500 : 16'd0;
      end else begin
         b.on_ms  = 16'($urandom_range(16'hffff));
         b.off_ms = ($urandom_range(19) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(16'hffff - b.on_ms));
      end
      return b;
   endfunction

   function automatic led_beat_type good_ack();
      led_beat_type b;
      b      = noise_beat();
      b.kind = lcf_pkg::KIND_ACK;
      b.berr = lcf_pkg::BERR_NONE;
      b.ack  = lcf_pkg::ACK_ACCEPT;
      return b;
   endfunction

   function automatic led_beat_type bad_ack();
      led_beat_type b;
      b      = noise_beat();
      b.kind = lcf_pkg::KIND_ACK;
      if (b.berr == lcf_pkg::BERR_NONE && b.ack == lcf_pkg::ACK_ACCEPT) b.ack = 8'h00;
      return b;
   endfunction

   task automatic send(input led_beat_type b);
      if (!calm && $urandom_range(99) < 32) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start           <= 1'b1;
      req_item_kind   <= b.kind;
      req_opcode      <= b.op;
      req_led_index   <= b.led;
      req_red         <= b.red;
      req_green       <= b.green;
      req_blue        <= b.blue;
      req_level       <= b.level;
      req_turn_on     <= b.turn_on;
      req_on_time_ms  <= b.on_ms;
      req_off_time_ms <= b.off_ms;
      req_bus_error   <= b.berr;
      req_ack_value   <= b.ack;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats++;
   endtask

   // hold off until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (waiting != 0 || busy) @(posedge clock);
   endtask

   initial begin
      #1_000_000;
      $display("led_command_framer_with_cache_test: errors");
      $finish;
   end

   initial begin
      int  directed;
      int  fails;
      int  roll;
      bit  paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));   // nothing pending
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_COLOR, 8'd16, 8'h11, 8'h22, 8'h33, 8'h00,
              1'b0, 16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));   // first LED out of range
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BRIGHT, 8'd255, 8'h00, 8'h00, 8'h00, 8'hff,
              1'b1, 16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(mk(lcf_pkg::KIND_REQ, OP_ILLEGAL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BLINK, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'hffff, 16'd1, lcf_pkg::BERR_NONE, 8'h00)); // on+off overflows 16 bits
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_COLOR, 8'd0, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_COLOR, 8'd0, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));   // cache hit
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BRIGHT, 8'd15, 8'h00, 8'h00, 8'h00, 8'hff,
              1'b0, 16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_ONOFF, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));   // request while pending
      send(ack_beat(lcf_pkg::BERR_WRITE, lcf_pkg::ACK_ACCEPT));
      send(ack_beat(BERR_READ, lcf_pkg::ACK_ACCEPT));
      send(ack_beat(BERR_READ_ALT, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, 8'hff));          // last attempt fails, purge
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_ONOFF, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_ONOFF, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BLINK, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'hffff, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BLINK, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'hffff, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_BREATH, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));
      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));
      send(mk(lcf_pkg::KIND_REQ, lcf_pkg::OP_ONOFF, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
              16'd0, 16'd0, lcf_pkg::BERR_NONE, 8'h00));   // breath -> off keeps times
      send(ack_beat(lcf_pkg::BERR_NONE, lcf_pkg::ACK_ACCEPT));
      directed = beats;
      drain();

      while (beats - directed < RANDOM_BEATS) begin
         calm = (beats - directed >= 60) && (beats - directed < 100);
         if (!paused && beats - directed >= 110) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 70) begin
            send(request_beat());
            roll = int'($urandom_range(99));
            if (roll < 55)
               fails = 0;
            else if (roll < 85)
               fails = int'($urandom_range(1, TRIES - 1));
            else
               fails = TRIES;
            for (int i = 0; i < fails; i++) begin
               if ($urandom_range(9) == 0) send(request_beat());
               send(bad_ack());
            end
            if (fails < TRIES) send(good_ack());
         end else begin
            send(noise_beat());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("drove %0d beats (%0d directed), %0d results compared", beats, directed,
               checked);
      $display("covered cache hits, retries to the attempt limit, purges and malformed beats");
      if (fail_count == 0)
         $display("led_command_framer_with_cache_test: clean");
      else
         $display("led_command_framer_with_cache_test: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/lcf_pkg.sv
hw/rtl/lcf_datapath.sv
hw/rtl/lcf_ctrl.sv
hw/rtl/led_command_framer_with_cache.sv
hw/rtl/lcf_checker.sv
tb/sv/lcf_frame_checker.sv
tb/sv/led_command_framer_with_cache_test.sv
